>>> rtl/lru_pkg.sv
package lru_pkg;

    localparam int FRAMES      = 16;
    localparam int FRAME_BITS  = $clog2(FRAMES);
    localparam int ADDR_BITS   = 16;
    localparam int PAGE_SHIFT  = 10;
    localparam int PAGE_BITS   = ADDR_BITS - PAGE_SHIFT;
    localparam int FAULT_BITS  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int RES_BITS    = 1 + FRAME_BITS + 1 + PAGE_BITS + FAULT_BITS;
    localparam int OUT_BITS    = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                 last;
        logic [PAGE_BITS-1:0] page;
    } req_t;

    typedef struct packed {
        logic [FAULT_BITS-1:0] fault_total;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic                  evicted_valid;
        logic [FRAME_BITS-1:0] frame_index;
        logic                  hit;
    } res_t;

endpackage

>>> rtl/lru_page_replacement.sv
// LRU page replacement unit with 16 fully associative frames.
//
// Input stream: one transfer per memory access. tdata carries the 16-bit
// address; its page number is the address divided by 1024. tlast marks
// the final access of a run: after its result the frames and the fault
// count return to their reset values.
// Output stream: exactly one transfer per access, in order, giving hit,
// the frame now holding the page, the evicted page (if any) and the
// saturating fault count of the run including this access.
//
// An accepted access is written into the queue, and its result is then
// registered in the output register. Throughput: one access per cycle
// while the receiver is ready; tag compare and LRU update are combinational.
// A four-entry queue separates the input stage from the lookup engine.
// When the receiver stalls, the result is held in the output register,
// the queue fills and s_axis_tready falls once it is full.
// Reset clears the queue, the output valid flag, all frames (empty, ranked
// by index with frame 0 oldest) and the fault count.
module lru_page_replacement (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // address[15:0]
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // hit[0], frame_index[4:1], evicted_valid[5], evicted_page[11:6],
    // fault_total[43:12], zero fill[47:44]
    output logic [lru_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import lru_pkg::*;

    logic q_valid;
    logic q_ready;
    req_t q_req;
    res_t res;

    lru_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .address     (s_axis_tdata),
        .last_of_run (s_axis_tlast),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_req       (q_req)
    );

    lru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {{(OUT_BITS - RES_BITS){1'b0}}, res};

endmodule

>>> rtl/lru_front.sv
module lru_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lru_pkg::ADDR_BITS-1:0] address,
    input  logic                          last_of_run,
    output logic                          q_valid,
    input  logic                          q_ready,
    output lru_pkg::req_t                 q_req
);
    import lru_pkg::*;

    req_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push;
    logic                 pop;
    req_t                 new_req;

    assign in_ready = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_req    = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // keep only the page number of the address
    always_comb
    begin
        new_req.page = address[ADDR_BITS-1:PAGE_SHIFT];
        new_req.last = last_of_run;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_req;
        end
    end

endmodule

>>> rtl/lru_back.sv
module lru_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  lru_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output lru_pkg::res_t out_res
);
    import lru_pkg::*;

    logic [PAGE_BITS-1:0]  page_reg  [FRAMES];
    logic [PAGE_BITS-1:0]  page_next [FRAMES];
    logic [FRAMES-1:0]     valid_reg, valid_next;
    logic [FRAME_BITS-1:0] rank_reg  [FRAMES];
    logic [FRAME_BITS-1:0] rank_next [FRAMES];
    logic [FAULT_BITS-1:0] fault_reg, fault_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  res_reg, res_next;

    logic                  take;
    logic [FRAMES-1:0]     match;
    logic                  found;
    logic [FRAME_BITS-1:0] hit_idx;
    logic [FRAME_BITS-1:0] victim;
    logic [FRAME_BITS-1:0] slot;
    logic [FRAME_BITS-1:0] old_rank;

    assign q_ready   = !out_valid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        for (int k = 0; k < FRAMES; k++)
        begin
            match[k] = valid_reg[k] && (page_reg[k] == q_req.page);
        end
        found = |match;
        // scan from the top so the lowest index wins
        hit_idx = '0;
        victim  = '0;
        for (int k = FRAMES - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit_idx = FRAME_BITS'(k);
            end
            if (rank_reg[k] == '0)
            begin
                victim = FRAME_BITS'(k);
            end
        end
        slot     = found ? hit_idx : victim;
        old_rank = rank_reg[slot];
    end

    always_comb
    begin
        page_next      = page_reg;
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            out_valid_next         = 1'b1;
            res_next.hit           = found;
            res_next.frame_index   = slot;
            res_next.evicted_valid = !found && valid_reg[slot];
            res_next.evicted_page  = (!found && valid_reg[slot]) ? page_reg[slot] : '0;
            if (!found && fault_reg != '1)
            begin
                fault_next = fault_reg + 1'b1;
            end
            res_next.fault_total = fault_next;

            if (!found)
            begin
                page_next[slot]  = q_req.page;
                valid_next[slot] = 1'b1;
            end
            // promote: frames newer than the touched one age by one
            for (int k = 0; k < FRAMES; k++)
            begin
                if (FRAME_BITS'(k) == slot)
                begin
                    rank_next[k] = FRAME_BITS'(FRAMES - 1);
                end
                else if (rank_reg[k] > old_rank)
                begin
                    rank_next[k] = rank_reg[k] - 1'b1;
                end
            end

            // end of run: drop all frames and the count after the result
            if (q_req.last)
            begin
                fault_next = '0;
                valid_next = '0;
                for (int k = 0; k < FRAMES; k++)
                begin
                    page_next[k] = '0;
                    rank_next[k] = FRAME_BITS'(k);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < FRAMES; k++)
            begin
                page_reg[k] <= '0;
                rank_reg[k] <= FRAME_BITS'(k);
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            page_reg      <= page_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
